// ----- rtl/wsp_pkg.sv -----
// shared constants, codes and helpers of the writable shard picker
package wsp_pkg;

   localparam int MAX_SHARDS  = 64;
   localparam int PROBE_LIMIT = 16;
   localparam int COUNT_W     = 7;
   localparam int SHARD_W     = $clog2(MAX_SHARDS);
   localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
   localparam int HASH_W      = 64;
   localparam int MOD_BITS    = 8;
   localparam int MOD_STEPS   = HASH_W / MOD_BITS;
   localparam int STEP_W      = $clog2(MOD_STEPS);

   localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
   localparam logic [63:0] SEED_SALT   = 64'h6a09e667f3bcc909;

   // configuration register indexes
   localparam logic [1:0] CSR_SHARD_COUNT   = 2'd0;
   localparam logic [1:0] CSR_WRITABLE_MASK = 2'd1;
   localparam logic [1:0] CSR_DRAINING_MASK = 2'd2;

   typedef enum logic [1:0] {
      PATH_PREF  = 2'd0,
      PATH_PROBE = 2'd1,
      PATH_SCAN  = 2'd2,
      PATH_NONE  = 2'd3
   } path_type;

   function automatic logic usable(input logic [SHARD_W-1:0] s,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic [MAX_SHARDS-1:0] wmask,
                                   input logic [MAX_SHARDS-1:0] dmask);
      return ({{(COUNT_W-SHARD_W){1'b0}}, s} < cnt) && wmask[s] && !dmask[s];
   endfunction

endpackage

// ----- rtl/writable_shard_picker_unit.sv -----
// writable shard picker: preferred shard, splitmix probes, then lowest-index scan
//
//   channel   ports                                   direction
//   req       req_valid req_stall req_key_hash         in (stall out)
//   rsp       rsp_valid rsp_stall rsp_shard_index      out (stall in)
//             rsp_found rsp_pick_path
//   csr       csr_write csr_index csr_data             in
//
// one word at a time: a preferred hit ends after one modulo; each probe runs the
// mixer (on one shared 32x32 multiplier, 3 products per 64-bit multiply), then a
// modulo at 8 bits a cycle; a seed mix comes before the first probe; scan walks
// one shard a cycle.
// reset is synchronous; req_stall stays high from accept until the result is
// loaded in the output register, which holds under rsp_stall.
module writable_shard_picker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wsp_pkg::HASH_W-1:0]    req_key_hash,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wsp_pkg::COUNT_W-1:0]   rsp_shard_index,
   output logic                          rsp_found,
   output logic [1:0]                    rsp_pick_path,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [63:0]                   csr_data
);
   import wsp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_MIX_ADD,
      ST_MIX_MUL,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [COUNT_W-1:0]      shard_count_ff;
   logic [MAX_SHARDS-1:0]   writable_mask_ff;
   logic [MAX_SHARDS-1:0]   draining_mask_ff;

   logic [COUNT_W-1:0]      cnt_ff;
   logic [PROBE_W-1:0]      probes_ff;
   logic [PROBE_W-1:0]      probe_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    mod_probe_ff;
   logic                    mix_b_ff;
   logic                    first_mix_ff;
   logic [HASH_W-1:0]       div_ff;
   logic [SHARD_W-1:0]      rem_ff;
   logic [HASH_W-1:0]       seed_ff;
   logic [HASH_W-1:0]       op_ff;
   logic [HASH_W-1:0]       acc_ff;
   logic [HASH_W-1:0]       prod_ff;
   logic [SHARD_W-1:0]      scan_ff;

   logic [COUNT_W-1:0]      res_index_ff;
   logic                    res_found_ff;
   path_type                res_path_ff;

   logic                    rsp_valid_ff;
   logic [COUNT_W-1:0]      rsp_index_ff;
   logic                    rsp_found_ff;
   path_type                rsp_path_ff;

   logic [COUNT_W-1:0]      cnt_in;
   logic [SHARD_W-1:0]      rem_in;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [63:0]             mul_const;
   logic [HASH_W-1:0]       mul_sum;
   logic [HASH_W-1:0]       mix_pre;
   logic                    rem_ok;
   logic                    scan_ok;

   assign cnt_in = (shard_count_ff > COUNT_W'(MAX_SHARDS)) ? COUNT_W'(MAX_SHARDS)
                                                            : shard_count_ff;

   // modulo by the shard count, 8 dividend bits a cycle, msb first
   always_comb begin
      logic [SHARD_W-1:0] r;
      logic [SHARD_W:0]   t;
      r = rem_ff;
      for (int k = 0; k < MOD_BITS; k++) begin
         t = {r, div_ff[HASH_W-1-k]};
         if (COUNT_W'(t) >= cnt_ff) begin
            t = t - (SHARD_W+1)'(cnt_ff);
         end
         r = t[SHARD_W-1:0];
      end
      rem_in = r;
   end

   // operand select for the shared multiplier: lo*lo, lo*hi, hi*lo
   assign mul_const = mix_b_ff ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a     = (step_ff == STEP_W'(2)) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b     = (step_ff == STEP_W'(1)) ? mul_const[63:32] : mul_const[31:0];
   assign mul_sum   = acc_ff + {prod_ff[31:0], 32'h0};
   assign mix_pre   = seed_ff + GOLDEN_STEP;

   assign rem_ok  = usable(rem_in, cnt_ff, writable_mask_ff, draining_mask_ff);
   assign scan_ok = usable(scan_ff, cnt_ff, writable_mask_ff, draining_mask_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         shard_count_ff   <= COUNT_W'(1);
         writable_mask_ff <= '0;
         draining_mask_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SHARD_COUNT:   shard_count_ff   <= csr_data[COUNT_W-1:0];
               CSR_WRITABLE_MASK: writable_mask_ff <= csr_data;
               CSR_DRAINING_MASK: draining_mask_ff <= csr_data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cnt_ff       <= cnt_in;
                  probes_ff    <= (cnt_in < COUNT_W'(PROBE_LIMIT)) ? PROBE_W'(cnt_in)
                                                                   : PROBE_W'(PROBE_LIMIT);
                  probe_ff     <= '0;
                  seed_ff      <= req_key_hash ^ SEED_SALT;
                  div_ff       <= req_key_hash;
                  rem_ff       <= '0;
                  step_ff      <= '0;
                  mod_probe_ff <= 1'b0;
                  if (cnt_in == '0) begin
                     res_index_ff <= '0;
                     res_found_ff <= 1'b0;
                     res_path_ff  <= PATH_NONE;
                     state_ff     <= ST_DONE;
                  end else begin
                     state_ff <= ST_MOD;
                  end
               end
            end
            ST_MOD: begin
               div_ff  <= div_ff << MOD_BITS;
               rem_ff  <= rem_in;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
                  if (rem_ok) begin
                     res_index_ff <= COUNT_W'(rem_in);
                     res_found_ff <= 1'b1;
                     res_path_ff  <= mod_probe_ff ? PATH_PROBE : PATH_PREF;
                     state_ff     <= ST_DONE;
                  end else if (!mod_probe_ff) begin
                     // seed mix before the first probe
                     first_mix_ff <= 1'b1;
                     state_ff     <= ST_MIX_ADD;
                  end else if (probe_ff + PROBE_W'(1) == probes_ff) begin
                     scan_ff  <= '0;
                     state_ff <= ST_SCAN;
                  end else begin
                     probe_ff <= probe_ff + PROBE_W'(1);
                     state_ff <= ST_MIX_ADD;
                  end
               end
            end
            ST_MIX_ADD: begin
               op_ff    <= mix_pre ^ (mix_pre >> 30);
               mix_b_ff <= 1'b0;
               step_ff  <= '0;
               state_ff <= ST_MIX_MUL;
            end
            ST_MIX_MUL: begin
               prod_ff <= mul_a * mul_b;
               case (step_ff)
                  STEP_W'(1): acc_ff <= prod_ff;
                  STEP_W'(2): acc_ff <= mul_sum;
                  default: ;
               endcase
               if (step_ff == STEP_W'(3)) begin
                  step_ff <= '0;
                  if (!mix_b_ff) begin
                     op_ff    <= mul_sum ^ (mul_sum >> 27);
                     mix_b_ff <= 1'b1;
                  end else begin
                     seed_ff <= mul_sum ^ (mul_sum >> 31);
                     if (first_mix_ff) begin
                        first_mix_ff <= 1'b0;
                        state_ff     <= ST_MIX_ADD;
                     end else begin
                        div_ff       <= mul_sum ^ (mul_sum >> 31);
                        rem_ff       <= '0;
                        mod_probe_ff <= 1'b1;
                        state_ff     <= ST_MOD;
                     end
                  end
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + SHARD_W'(1);
               if (scan_ok) begin
                  res_index_ff <= COUNT_W'(scan_ff);
                  res_found_ff <= 1'b1;
                  res_path_ff  <= PATH_SCAN;
                  state_ff     <= ST_DONE;
               end else if (COUNT_W'(scan_ff) == cnt_ff - COUNT_W'(1)) begin
                  res_index_ff <= cnt_ff;
                  res_found_ff <= 1'b0;
                  res_path_ff  <= PATH_NONE;
                  state_ff     <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= res_index_ff;
                  rsp_found_ff <= res_found_ff;
                  rsp_path_ff  <= res_path_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shard_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_pick_path   = rsp_path_ff;

`ifndef SYNTHESIS
   // found word never carries the none path, and a miss always does
   a_found_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_pick_path != PATH_NONE)))
      else $error("found flag and pick path disagree");

   // a found shard is always inside the shard range
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_shard_index < COUNT_W'(MAX_SHARDS)))
      else $error("found shard out of range");

   // probe counter never runs past the probe limit
   a_probe_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_DONE) |-> (probe_ff < probes_ff))
      else $error("probe counter past limit");

   // multiplier sequence uses only four steps
   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_MUL) |-> (step_ff <= STEP_W'(3)))
      else $error("multiply step out of range");

   // a word is only loaded from the done state
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset)) |-> ($past(state_ff) == ST_DONE))
      else $error("result word loaded outside done state");
`endif

endmodule

// ----- tb/tb_writable_shard_picker_unit.sv -----
// testbench of the writable shard picker: directed table, then random register settings and keys
module tb_writable_shard_picker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import wsp_pkg::*;

   localparam int RANDOM_KEYS  = 1300;
   localparam int QUIET_KEYS   = 150;
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      logic [COUNT_W-1:0] shard;
      logic               found;
      path_type           path;
   } placement_type;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic [63:0]        wmask;
      logic [63:0]        dmask;
      logic [63:0]        hash;
      bit                 typed;
      placement_type      want;
   } pick_case_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [HASH_W-1:0]   req_key_hash;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COUNT_W-1:0]  rsp_shard_index;
   logic                rsp_found;
   logic [1:0]          rsp_pick_path;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [63:0]         csr_data;

   // register copies that the predictor works from
   logic [COUNT_W-1:0]  cfg_count;
   logic [63:0]         cfg_wmask;
   logic [63:0]         cfg_dmask;

   placement_type       pending_picks[$];
   placement_type       oldest_pick;
   pick_case_type       pick_cases[$];
   int                  mismatches;
   int                  keys_sent;
   int                  picks_seen;
   int                  settings_used;
   int                  by_path[4];
   bit                  quiet;

   writable_shard_picker_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_hash    (req_key_hash),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shard_index (rsp_shard_index),
      .rsp_found       (rsp_found),
      .rsp_pick_path   (rsp_pick_path),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] splitmix_next(input logic [63:0] v);
      logic [63:0] z;
      z = v + GOLDEN_STEP;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic bit shard_open(input logic [63:0] s, input logic [63:0] cnt);
      return (s < cnt) && (s < 64) && cfg_wmask[s[5:0]] && !cfg_dmask[s[5:0]];
   endfunction

   function automatic placement_type place_key(input logic [63:0] hash);
      logic [63:0]   cnt;
      logic [63:0]   probes;
      logic [63:0]   seed;
      logic [63:0]   s;
      placement_type p;
      // counts above the shard limit saturate
      cnt = (cfg_count > COUNT_W'(MAX_SHARDS)) ? 64'(MAX_SHARDS) : 64'(cfg_count);
      p.shard = '0;
      p.found = 1'b0;
      p.path  = PATH_NONE;
      if (cnt == 0)
         return p;
      s = hash % cnt;
      if (shard_open(s, cnt)) begin
         p.shard = s[COUNT_W-1:0];
         p.found = 1'b1;
         p.path  = PATH_PREF;
         return p;
      end
      probes = (cnt < 64'(PROBE_LIMIT)) ? cnt : 64'(PROBE_LIMIT);
      seed = splitmix_next(hash ^ SEED_SALT);
      for (int i = 0; i < probes; i++) begin
         seed = splitmix_next(seed);
         s = seed % cnt;
         if (shard_open(s, cnt)) begin
            p.shard = s[COUNT_W-1:0];
            p.found = 1'b1;
            p.path  = PATH_PROBE;
            return p;
         end
      end
      for (s = 0; s < cnt; s++) begin
         if (shard_open(s, cnt)) begin
            p.shard = s[COUNT_W-1:0];
            p.found = 1'b1;
            p.path  = PATH_SCAN;
            return p;
         end
      end
      p.shard = cnt[COUNT_W-1:0];
      return p;
   endfunction

   function automatic logic [63:0] key_hash_sample();
      case ($urandom_range(0, 15))
         0:       return '1;
         1:       return '0;
         2:       return rand64() >> $urandom_range(1, 63);
         3:       return rand64() | (64'd1 << 63);
         default: return rand64();
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic add_case(input logic [COUNT_W-1:0] count, input logic [63:0] wmask,
                           input logic [63:0] dmask, input logic [63:0] hash,
                           input bit typed, input logic [COUNT_W-1:0] shard,
                           input logic found, input path_type path);
      pick_case_type c;
      c.count      = count;
      c.wmask      = wmask;
      c.dmask      = dmask;
      c.hash       = hash;
      c.typed      = typed;
      c.want.shard = shard;
      c.want.found = found;
      c.want.path  = path;
      pick_cases.push_back(c);
   endtask

   task automatic send_key(input logic [63:0] hash, input placement_type want);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_key_hash <= hash;
      do @(posedge clock); while (req_stall);
      pending_picks.push_back(want);
      keys_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold off until every outstanding pick has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   task automatic apply_config(input logic [COUNT_W-1:0] cnt, input logic [63:0] wm,
                               input logic [63:0] dm);
      logic [63:0] count_word;
      logic [63:0] upper_bits;
      settle();
      // upper bits of the count word are don't-care
      upper_bits = rand64();
      count_word = 64'(cnt);
      if ($urandom_range(0, 1) != 0)
         count_word[63:COUNT_W] = upper_bits[63:COUNT_W];
      write_csr(CSR_SHARD_COUNT, count_word);
      write_csr(CSR_WRITABLE_MASK, wm);
      write_csr(CSR_DRAINING_MASK, dm);
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_count = cnt;
      cfg_wmask = wm;
      cfg_dmask = dm;
      settings_used++;
   endtask

   task automatic pick_config(output logic [COUNT_W-1:0] cnt, output logic [63:0] wm,
                              output logic [63:0] dm);
      case ($urandom_range(0, 9)) inside
         0:       cnt = 7'd0;
         1:       cnt = 7'd1;
         2:       cnt = 7'($urandom_range(2, 8));
         3, 4:    cnt = 7'($urandom_range(9, 63));
         5, 6:    cnt = 7'd64;
         7:       cnt = 7'($urandom_range(65, 127));
         8:       cnt = 7'd127;
         default: cnt = 7'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 7))
         0:       wm = '1;
         1:       wm = rand64() & rand64();
         2:       wm = 64'd1 << $urandom_range(0, 63);
         3:       wm = rand64() | rand64();
         4:       wm = '0;
         default: wm = rand64();
      endcase
      case ($urandom_range(0, 7)) inside
         0, 1:    dm = '0;
         2:       dm = rand64() & rand64();
         3:       dm = 64'd1 << $urandom_range(0, 63);
         4:       dm = '1;
         default: dm = rand64();
      endcase
   endtask

   // result side: stall bursts, none once the run goes quiet
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         picks_seen++;
         if (pending_picks.size() == 0) begin
            flag_mismatch($sformatf("result word with nothing expected (shard %0d)",
                                    rsp_shard_index));
         end else begin
            oldest_pick = pending_picks.pop_front();
            by_path[oldest_pick.path]++;
            if (rsp_shard_index !== oldest_pick.shard)
               flag_mismatch($sformatf("word %0d shard_index %0d, expected %0d", picks_seen,
                                       rsp_shard_index, oldest_pick.shard));
            if (rsp_found !== oldest_pick.found)
               flag_mismatch($sformatf("word %0d found %0b, expected %0b", picks_seen,
                                       rsp_found, oldest_pick.found));
            if (rsp_pick_path !== oldest_pick.path)
               flag_mismatch($sformatf("word %0d pick_path %0d, expected %0d", picks_seen,
                                       rsp_pick_path, oldest_pick.path));
         end
      end
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d picks outstanding", pending_picks.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] cnt;
      logic [63:0]        wm;
      logic [63:0]        dm;
      logic [63:0]        h;
      placement_type      want;
      int                 done;
      int                 run_len;
      int                 k;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_key_hash = '0;
      csr_write    = 1'b0;
      csr_index    = CSR_SHARD_COUNT;
      csr_data     = '0;
      quiet        = 1'b0;
      mismatches   = 0;
      keys_sent    = 0;
      picks_seen   = 0;
      settings_used = 0;
      by_path      = '{default: 0};
      cfg_count    = 7'd1;
      cfg_wmask    = '0;
      cfg_dmask    = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // first row runs on the reset values of the registers
      add_case(7'd1, '0, '0, 64'd0, 1, 7'd1, 1'b0, PATH_NONE);
      add_case(7'd0, '1, '0, '1, 1, 7'd0, 1'b0, PATH_NONE);
      add_case(7'd0, '1, '0, '0, 1, 7'd0, 1'b0, PATH_NONE);
      add_case(7'd1, 64'd1, '0, '0, 1, 7'd0, 1'b1, PATH_PREF);
      add_case(7'd1, 64'd1, '0, '1, 1, 7'd0, 1'b1, PATH_PREF);
      add_case(7'd1, 64'd1, 64'd1, 64'd7, 1, 7'd1, 1'b0, PATH_NONE);
      add_case(7'd64, '1, '0, '1, 1, 7'd63, 1'b1, PATH_PREF);
      add_case(7'd64, '1, '0, '0, 1, 7'd0, 1'b1, PATH_PREF);
      add_case(7'd64, '1, '0, 64'h8000_0000_0000_0000, 1, 7'd0, 1'b1, PATH_PREF);
      // saturated count
      add_case(7'd127, '1, '0, '1, 1, 7'd63, 1'b1, PATH_PREF);
      add_case(7'd127, '0, '0, 64'h1234_5678_9abc_def0, 1, 7'd64, 1'b0, PATH_NONE);
      add_case(7'd65, '1, '1, '1, 1, 7'd64, 1'b0, PATH_NONE);
      // mask bits past the count do not count
      add_case(7'd4, ~64'hf, '0, 64'd5, 1, 7'd4, 1'b0, PATH_NONE);
      add_case(7'd64, 64'd1 << 63, '0, 64'd63, 1, 7'd63, 1'b1, PATH_PREF);
      add_case(7'd64, 64'd1 << 63, '0, 64'd0, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd64, 64'h5555_5555_5555_5555, '0, 64'hdead_beef_0bad_f00d, 0, '0, 1'b0,
               PATH_NONE);
      add_case(7'd64, '1, 64'haaaa_aaaa_aaaa_aaaa, 64'd1, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd3, 64'd4, '0, 64'd0, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd17, 64'd1 << 16, '0, 64'd0, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd64, 64'd1, '0, 64'h0123_4567_89ab_cdef, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd2, 64'd2, '0, 64'hffff_ffff_ffff_fffe, 0, '0, 1'b0, PATH_NONE);
      add_case(7'd127, '1, ~64'd1, 64'hffff_0000_ffff_0000, 0, '0, 1'b0, PATH_NONE);

      foreach (pick_cases[i]) begin
         if (pick_cases[i].count != cfg_count || pick_cases[i].wmask != cfg_wmask ||
             pick_cases[i].dmask != cfg_dmask)
            apply_config(pick_cases[i].count, pick_cases[i].wmask, pick_cases[i].dmask);
         want = pick_cases[i].typed ? pick_cases[i].want : place_key(pick_cases[i].hash);
         send_key(pick_cases[i].hash, want);
         if ($urandom_range(0, 2) == 0)
            idle_sender($urandom_range(1, 13));
      end

      done = 0;
      while (done < RANDOM_KEYS) begin
         pick_config(cnt, wm, dm);
         apply_config(cnt, wm, dm);
         run_len = $urandom_range(60, 120);
         k = 0;
         // the quiet tail stays on one setting so nothing holds the sender back
         while (done < RANDOM_KEYS && (k < run_len || quiet)) begin
            quiet = (done >= RANDOM_KEYS - QUIET_KEYS);
            h = key_hash_sample();
            send_key(h, place_key(h));
            done++;
            k++;
            if (!quiet) begin
               if ($urandom_range(0, 59) == 0)
                  settle();
               else if ($urandom_range(0, 4) == 0)
                  idle_sender($urandom_range(1, 13));
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d key hashes placed over %0d register settings, %0d picks checked",
               keys_sent, settings_used, picks_seen);
      $display("by path: %0d preferred, %0d probe, %0d scan, %0d unplaced",
               by_path[PATH_PREF], by_path[PATH_PROBE], by_path[PATH_SCAN],
               by_path[PATH_NONE]);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
